FILE: design/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants of the box side classifier
// Register map codes, ego edge definitions and the control and flag
// bundles that pass between the pipeline, the lanes and the merge stage.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // APB register file geometry.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;

    // One lane per obstacle corner, one cross product test per ego edge.
    localparam int NUM_CORNERS = 4;
    localparam int NUM_LANES   = 4;
    localparam int NUM_EDGES   = 4;

    typedef logic [1:0] corner_idx_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    // Register indexes, in register map order.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_EGO_V0_X = 3'd0,
        REG_EGO_V0_Y = 3'd1,
        REG_EGO_V1_X = 3'd2,
        REG_EGO_V1_Y = 3'd3,
        REG_EGO_V2_X = 3'd4,
        REG_EGO_V2_Y = 3'd5,
        REG_EGO_V3_X = 3'd6,
        REG_EGO_V3_Y = 3'd7
    } bsc_reg_e;

    // Ego edges tested against each obstacle corner.
    localparam int EDGE_F = 0;  // lateral edge v1 -> v2
    localparam int EDGE_H = 1;  // lateral edge v0 -> v3
    localparam int EDGE_L = 2;  // edge v1 -> v0
    localparam int EDGE_R = 3;  // edge v2 -> v3

    // Edge vector is corner[head] - corner[tail]; the corner offset is taken
    // relative to corner[tail].
    localparam corner_idx_t EDGE_HEAD [NUM_EDGES] = '{2'd2, 2'd3, 2'd0, 2'd3};
    localparam corner_idx_t EDGE_TAIL [NUM_EDGES] = '{2'd1, 2'd0, 2'd1, 2'd2};

    // Load enables of the three lane stages.
    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
    } bsc_lane_ctrl_t;

    // Signs found by one lane for its corner.
    typedef struct packed {
        logic f_neg;   // cross against edge v1->v2 below zero
        logic h_pos;   // cross against edge v0->v3 above zero
        logic l_neg;   // cross against edge v1->v0 below zero
        logic r_pos;   // cross against edge v2->v3 above zero
    } bsc_lane_flags_t;

endpackage

FILE: design/bsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bsc_cfg_regs: ego corner register file
// APB write/read access to the eight ego corner coordinates, plus a
// registered copy of the four ego edge vectors used by the lanes.
// ----------------------------------------------------------------------------
module bsc_cfg_regs #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bsc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bsc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bsc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic signed [COORD_WIDTH-1:0]       ego_x [bsc_pkg::NUM_CORNERS],
    output logic signed [COORD_WIDTH-1:0]       ego_y [bsc_pkg::NUM_CORNERS],
    output logic signed [COORD_WIDTH:0]         edge_x [bsc_pkg::NUM_EDGES],
    output logic signed [COORD_WIDTH:0]         edge_y [bsc_pkg::NUM_EDGES]
);
    import bsc_pkg::*;

    localparam int DW = COORD_WIDTH + 1;

    logic signed [COORD_WIDTH-1:0] cfg_reg  [NUM_REGS];
    logic signed [COORD_WIDTH-1:0] cfg_next [NUM_REGS];
    logic signed [DW-1:0]          edge_x_reg [NUM_EDGES];
    logic signed [DW-1:0]          edge_y_reg [NUM_EDGES];
    logic signed [DW-1:0]          edge_x_next [NUM_EDGES];
    logic signed [DW-1:0]          edge_y_next [NUM_EDGES];
    logic                          wr_en;
    reg_idx_t                      wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[APB_ADDR_W-1:2];

    // Register write on the access phase.
    always_comb begin
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_next[i] = cfg_reg[i];
        end
        if (wr_en) begin
            cfg_next[wr_idx] = pwdata[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_reg[i] <= cfg_next[i];
            end
        end
    end

    // Read data is the stored field, zero extended.
    assign prdata = APB_DATA_W'($unsigned(cfg_reg[wr_idx]));

    // Corner views of the register file.
    assign ego_x[0] = cfg_reg[REG_EGO_V0_X];
    assign ego_y[0] = cfg_reg[REG_EGO_V0_Y];
    assign ego_x[1] = cfg_reg[REG_EGO_V1_X];
    assign ego_y[1] = cfg_reg[REG_EGO_V1_Y];
    assign ego_x[2] = cfg_reg[REG_EGO_V2_X];
    assign ego_y[2] = cfg_reg[REG_EGO_V2_Y];
    assign ego_x[3] = cfg_reg[REG_EGO_V3_X];
    assign ego_y[3] = cfg_reg[REG_EGO_V3_Y];

    // Edge vectors are registered from the corner differences and follow the corners in the next cycle.
    for (genvar k = 0; k < NUM_EDGES; k++) begin : g_edge
        assign edge_x_next[k] = {ego_x[EDGE_HEAD[k]][COORD_WIDTH-1], ego_x[EDGE_HEAD[k]]}
                              - {ego_x[EDGE_TAIL[k]][COORD_WIDTH-1], ego_x[EDGE_TAIL[k]]};
        assign edge_y_next[k] = {ego_y[EDGE_HEAD[k]][COORD_WIDTH-1], ego_y[EDGE_HEAD[k]]}
                              - {ego_y[EDGE_TAIL[k]][COORD_WIDTH-1], ego_y[EDGE_TAIL[k]]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                edge_x_reg[k] <= '0;
                edge_y_reg[k] <= '0;
            end else begin
                edge_x_reg[k] <= edge_x_next[k];
                edge_y_reg[k] <= edge_y_next[k];
            end
        end

        assign edge_x[k] = edge_x_reg[k];
        assign edge_y[k] = edge_y_reg[k];
    end

endmodule

FILE: design/bsc_lane.sv
// ----------------------------------------------------------------------------
// bsc_lane: cross product sign lane for one obstacle corner
// Three stages: corner offsets, registered products, sign of the difference
// for each of the four ego edges.
// ----------------------------------------------------------------------------
module bsc_lane #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                              aclk,
    input  bsc_pkg::bsc_lane_ctrl_t           ctrl,
    input  logic signed [COORD_WIDTH-1:0]     px,
    input  logic signed [COORD_WIDTH-1:0]     py,
    input  logic signed [COORD_WIDTH-1:0]     ego_x [bsc_pkg::NUM_CORNERS],
    input  logic signed [COORD_WIDTH-1:0]     ego_y [bsc_pkg::NUM_CORNERS],
    input  logic signed [COORD_WIDTH:0]       edge_x [bsc_pkg::NUM_EDGES],
    input  logic signed [COORD_WIDTH:0]       edge_y [bsc_pkg::NUM_EDGES],
    output bsc_pkg::bsc_lane_flags_t          flags
);
    import bsc_pkg::*;

    localparam int DW = COORD_WIDTH + 1;   // coordinate difference
    localparam int PW = 2 * DW;            // exact product
    localparam int XW = PW + 1;            // exact difference of products

    logic signed [DW-1:0] dx_reg [NUM_EDGES];
    logic signed [DW-1:0] dy_reg [NUM_EDGES];
    logic signed [PW-1:0] pa_reg [NUM_EDGES];
    logic signed [PW-1:0] pb_reg [NUM_EDGES];
    logic                 neg_reg [NUM_EDGES];
    logic                 pos_reg [NUM_EDGES];

    for (genvar k = 0; k < NUM_EDGES; k++) begin : g_edge
        logic signed [DW-1:0] dx_next;
        logic signed [DW-1:0] dy_next;
        logic signed [PW-1:0] pa_next;
        logic signed [PW-1:0] pb_next;
        logic signed [XW-1:0] cross_diff;

        // Offset of the corner from the edge's tail corner.
        assign dx_next = {px[COORD_WIDTH-1], px}
                       - {ego_x[EDGE_TAIL[k]][COORD_WIDTH-1], ego_x[EDGE_TAIL[k]]};
        assign dy_next = {py[COORD_WIDTH-1], py}
                       - {ego_y[EDGE_TAIL[k]][COORD_WIDTH-1], ego_y[EDGE_TAIL[k]]};

        // The two terms of edge x offset.
        assign pa_next = edge_x[k] * dy_reg[k];
        assign pb_next = edge_y[k] * dx_reg[k];

        // Exact difference; only its sign is kept.
        assign cross_diff = XW'(pa_reg[k]) - XW'(pb_reg[k]);

        always_ff @(posedge aclk) begin
            if (ctrl.load1) begin
                dx_reg[k] <= dx_next;
                dy_reg[k] <= dy_next;
            end
            if (ctrl.load2) begin
                pa_reg[k] <= pa_next;
                pb_reg[k] <= pb_next;
            end
            if (ctrl.load3) begin
                neg_reg[k] <= cross_diff[XW-1];
                pos_reg[k] <= !cross_diff[XW-1] && (cross_diff != '0);
            end
        end
    end

    assign flags.f_neg = neg_reg[EDGE_F];
    assign flags.h_pos = pos_reg[EDGE_H];
    assign flags.l_neg = neg_reg[EDGE_L];
    assign flags.r_pos = pos_reg[EDGE_R];

endmodule

FILE: design/bsc_merge.sv
// ----------------------------------------------------------------------------
// bsc_merge: combines the lane flags into one classification
// Reduces the four corners' signs, applies the excluded flag and holds the
// result beat in the output register.
// ----------------------------------------------------------------------------
module bsc_merge #(
    parameter int ID_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic                         valid_in,
    input  logic [ID_WIDTH-1:0]          id_in,
    input  logic                         excluded_in,
    input  bsc_pkg::bsc_lane_flags_t     flags [bsc_pkg::NUM_LANES],
    output logic                         m_valid,
    output logic [ID_WIDTH-1:0]          m_result_id,
    output logic                         m_adjacent,
    output logic                         m_left_of_ego,
    output logic                         m_right_of_ego
);
    import bsc_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [ID_WIDTH-1:0] id_reg;
    logic                adj_reg;
    logic                left_reg;
    logic                right_reg;
    logic                any_f_neg;
    logic                any_h_pos;
    logic                all_l_neg;
    logic                all_r_pos;
    logic                adj;

    // Reduce across the corners.
    always_comb begin
        any_f_neg = 1'b0;
        any_h_pos = 1'b0;
        all_l_neg = 1'b1;
        all_r_pos = 1'b1;
        for (int i = 0; i < NUM_LANES; i++) begin
            any_f_neg = any_f_neg | flags[i].f_neg;
            any_h_pos = any_h_pos | flags[i].h_pos;
            all_l_neg = all_l_neg & flags[i].l_neg;
            all_r_pos = all_r_pos & flags[i].r_pos;
        end
    end

    assign adj        = any_f_neg && any_h_pos && !excluded_in;
    assign valid_next = load ? valid_in : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            id_reg    <= id_in;
            adj_reg   <= adj;
            left_reg  <= adj && all_l_neg;
            right_reg <= adj && all_r_pos;
        end
    end

    assign m_valid        = valid_reg;
    assign m_result_id    = id_reg;
    assign m_adjacent     = adj_reg;
    assign m_left_of_ego  = left_reg;
    assign m_right_of_ego = right_reg;

endmodule

FILE: design/box_side_classifier_unit.sv
// ----------------------------------------------------------------------------
// box_side_classifier_unit: obstacle box side test against the ego box
// Classifies each obstacle box as adjacent to the ego, wholly left or
// wholly right, using exact edge cross products in signed fixed point.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  s_*     | in        | s_valid / s_ready | obstacle id, excluded, 4 corners
//  m_*     | out       | m_valid / m_ready | id, adjacent, left, right
//  apb     | in        | psel/penable      | ego corner registers
//
//  One obstacle beat per cycle is accepted while the result side is not stalled;
//  a result is presented once the beat has passed the offset, product, sign and
//  merge registers.
//  The datapath is the four parallel corner lanes, each with eight
//  registered multipliers, and the merge register.
//  Each stage holds its beat only while the stage after it is full and stalled,
//  so bubbles are squeezed out under backpressure.
//  Reset clears the ego registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module box_side_classifier_unit #(
    parameter int COORD_WIDTH = 24,
    parameter int ID_WIDTH    = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bsc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bsc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bsc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    // Obstacle beats
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ID_WIDTH-1:0]                 s_obstacle_id,
    input  logic                                s_excluded,
    input  logic signed [COORD_WIDTH-1:0]       s_obs_v0_x,
    input  logic signed [COORD_WIDTH-1:0]       s_obs_v0_y,
    input  logic signed [COORD_WIDTH-1:0]       s_obs_v1_x,
    input  logic signed [COORD_WIDTH-1:0]       s_obs_v1_y,
    input  logic signed [COORD_WIDTH-1:0]       s_obs_v2_x,
    input  logic signed [COORD_WIDTH-1:0]       s_obs_v2_y,
    input  logic signed [COORD_WIDTH-1:0]       s_obs_v3_x,
    input  logic signed [COORD_WIDTH-1:0]       s_obs_v3_y,
    // Result beats
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ID_WIDTH-1:0]                 m_result_id,
    output logic                                m_adjacent,
    output logic                                m_left_of_ego,
    output logic                                m_right_of_ego
);
    import bsc_pkg::*;

    logic signed [COORD_WIDTH-1:0] ego_x  [NUM_CORNERS];
    logic signed [COORD_WIDTH-1:0] ego_y  [NUM_CORNERS];
    logic signed [COORD_WIDTH:0]   edge_x [NUM_EDGES];
    logic signed [COORD_WIDTH:0]   edge_y [NUM_EDGES];
    logic signed [COORD_WIDTH-1:0] obs_x  [NUM_LANES];
    logic signed [COORD_WIDTH-1:0] obs_y  [NUM_LANES];
    bsc_lane_flags_t               flags  [NUM_LANES];
    bsc_lane_ctrl_t                lane_ctrl;

    logic                v1_reg, v2_reg, v3_reg;
    logic                v1_next, v2_next, v3_next;
    logic                ready1, ready2, ready3, ready4;
    logic [ID_WIDTH-1:0] id1_reg, id2_reg, id3_reg;
    logic                ex1_reg, ex2_reg, ex3_reg;

    // Register file.
    bsc_cfg_regs #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .ego_x   (ego_x),
        .ego_y   (ego_y),
        .edge_x  (edge_x),
        .edge_y  (edge_y)
    );

    // Stage readiness: a stage loads when it is empty or its successor moves.
    assign ready4  = !m_valid || m_ready;
    assign ready3  = !v3_reg || ready4;
    assign ready2  = !v2_reg || ready3;
    assign ready1  = !v1_reg || ready2;
    assign s_ready = ready1;

    assign v1_next = ready1 ? s_valid : v1_reg;
    assign v2_next = ready2 ? v1_reg  : v2_reg;
    assign v3_next = ready3 ? v2_reg  : v3_reg;

    assign lane_ctrl.load1 = ready1;
    assign lane_ctrl.load2 = ready2;
    assign lane_ctrl.load3 = ready3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Id and excluded flag travel alongside the lanes.
    always_ff @(posedge aclk) begin
        if (ready1) begin
            id1_reg <= s_obstacle_id;
            ex1_reg <= s_excluded;
        end
        if (ready2) begin
            id2_reg <= id1_reg;
            ex2_reg <= ex1_reg;
        end
        if (ready3) begin
            id3_reg <= id2_reg;
            ex3_reg <= ex2_reg;
        end
    end

    // Obstacle corners, one per lane.
    assign obs_x[0] = s_obs_v0_x;
    assign obs_y[0] = s_obs_v0_y;
    assign obs_x[1] = s_obs_v1_x;
    assign obs_y[1] = s_obs_v1_y;
    assign obs_x[2] = s_obs_v2_x;
    assign obs_y[2] = s_obs_v2_y;
    assign obs_x[3] = s_obs_v3_x;
    assign obs_y[3] = s_obs_v3_y;

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        bsc_lane #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_lane (
            .aclk   (aclk),
            .ctrl   (lane_ctrl),
            .px     (obs_x[i]),
            .py     (obs_y[i]),
            .ego_x  (ego_x),
            .ego_y  (ego_y),
            .edge_x (edge_x),
            .edge_y (edge_y),
            .flags  (flags[i])
        );
    end

    // Merge and output register.
    bsc_merge #(
        .ID_WIDTH (ID_WIDTH)
    ) u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (ready4),
        .valid_in       (v3_reg),
        .id_in          (id3_reg),
        .excluded_in    (ex3_reg),
        .flags          (flags),
        .m_valid        (m_valid),
        .m_result_id    (m_result_id),
        .m_adjacent     (m_adjacent),
        .m_left_of_ego  (m_left_of_ego),
        .m_right_of_ego (m_right_of_ego)
    );

endmodule

FILE: test/box_side_classifier_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_side_classifier_unit_test: self-checking bench for the box side classifier
// Programs the ego corners over APB, streams obstacle boxes through the input
// channel with random gaps and random result backpressure, and checks every
// result beat against a typed verdict or an exact cross product model of the side test.
// ----------------------------------------------------------------------------
module box_side_classifier_unit_test;
    import bsc_pkg::*;

    localparam int     CW           = 24;
    localparam int     IDW          = 16;
    localparam longint C_MAX        = (longint'(1) << (CW - 1)) - 1;
    localparam longint C_MIN        = -(longint'(1) << (CW - 1));
    localparam longint U            = 256;      // one unit in fixed point with 8 fraction bits
    localparam int     RESET_ROWS   = 4;        // directed rows run with the reset ego
    localparam int     PHASE_ITEMS  = 98;
    localparam int     DRAIN_CYCLES = 12;
    localparam int     CYCLE_LIMIT  = 200000;
    localparam logic [2:0] NO_SIDE  = 3'b000;

    typedef struct packed {
        logic [IDW-1:0]     id;
        logic               excluded;
        logic [3:0][CW-1:0] x;
        logic [3:0][CW-1:0] y;
    } obstacle_t;

    typedef struct packed {
        logic [IDW-1:0] id;
        logic           adjacent;
        logic           left_of_ego;
        logic           right_of_ego;
    } side_verdict_t;

    typedef struct packed {
        obstacle_t     box;
        logic          known;
        side_verdict_t verdict;
    } probe_row_t;

    typedef enum int {
        SHAPE_RECT,
        SHAPE_ROTATED,
        SHAPE_WILD,
        SHAPE_EXTREME,
        SHAPE_DEGENERATE
    } ego_shape_e;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [IDW-1:0]        s_obstacle_id = '0;
    logic                  s_excluded = 1'b0;
    logic [CW-1:0]         s_obs_v0_x = '0;
    logic [CW-1:0]         s_obs_v0_y = '0;
    logic [CW-1:0]         s_obs_v1_x = '0;
    logic [CW-1:0]         s_obs_v1_y = '0;
    logic [CW-1:0]         s_obs_v2_x = '0;
    logic [CW-1:0]         s_obs_v2_y = '0;
    logic [CW-1:0]         s_obs_v3_x = '0;
    logic [CW-1:0]         s_obs_v3_y = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [IDW-1:0]        m_result_id;
    logic                  m_adjacent;
    logic                  m_left_of_ego;
    logic                  m_right_of_ego;

    // Ego corners as the block holds them, sign extended.
    longint ego_x [4] = '{0, 0, 0, 0};
    longint ego_y [4] = '{0, 0, 0, 0};

    side_verdict_t pending_verdicts [$];
    probe_row_t    probe_rows [$];
    int            idle_pct = 26;
    int            errors = 0;
    int            cycles = 0;

    box_side_classifier_unit #(
        .COORD_WIDTH(CW),
        .ID_WIDTH   (IDW)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_obstacle_id (s_obstacle_id),
        .s_excluded    (s_excluded),
        .s_obs_v0_x    (s_obs_v0_x),
        .s_obs_v0_y    (s_obs_v0_y),
        .s_obs_v1_x    (s_obs_v1_x),
        .s_obs_v1_y    (s_obs_v1_y),
        .s_obs_v2_x    (s_obs_v2_x),
        .s_obs_v2_y    (s_obs_v2_y),
        .s_obs_v3_x    (s_obs_v3_x),
        .s_obs_v3_y    (s_obs_v3_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_id   (m_result_id),
        .m_adjacent    (m_adjacent),
        .m_left_of_ego (m_left_of_ego),
        .m_right_of_ego(m_right_of_ego)
    );

    // Clock and run limit.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("box_side_classifier_unit_test: done, errors");
            $finish;
        end
    end

    // Result side backpressure.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Sign of the 2D cross product a x b; exact, since the operands stay below
    // 2^25 in magnitude.
    function automatic int cross_sign(longint ax, longint ay, longint bx, longint by);
        longint c;
        c = ax * by - ay * bx;
        if (c > 0)
            return 1;
        if (c < 0)
            return -1;
        return 0;
    endfunction

    // Side test of one obstacle box against the current ego corners.
    function automatic side_verdict_t classify_box(obstacle_t b);
        side_verdict_t v;
        longint        px;
        longint        py;
        logic          any_f_neg;
        logic          any_h_pos;
        logic          all_left;
        logic          all_right;
        any_f_neg = 1'b0;
        any_h_pos = 1'b0;
        all_left  = 1'b1;
        all_right = 1'b1;
        for (int i = 0; i < 4; i++) begin
            px = longint'($signed(b.x[i]));
            py = longint'($signed(b.y[i]));
            // Lateral edges v1->v2 and v0->v3 bound the adjacent band.
            if (cross_sign(ego_x[2] - ego_x[1], ego_y[2] - ego_y[1],
                           px - ego_x[1], py - ego_y[1]) < 0)
                any_f_neg = 1'b1;
            if (cross_sign(ego_x[3] - ego_x[0], ego_y[3] - ego_y[0],
                           px - ego_x[0], py - ego_y[0]) > 0)
                any_h_pos = 1'b1;
            // End edges v1->v0 and v2->v3 decide left and right.
            if (cross_sign(ego_x[0] - ego_x[1], ego_y[0] - ego_y[1],
                           px - ego_x[1], py - ego_y[1]) >= 0)
                all_left = 1'b0;
            if (cross_sign(ego_x[3] - ego_x[2], ego_y[3] - ego_y[2],
                           px - ego_x[2], py - ego_y[2]) <= 0)
                all_right = 1'b0;
        end
        v.id           = b.id;
        v.adjacent     = any_f_neg && any_h_pos && !b.excluded;
        v.left_of_ego  = v.adjacent && all_left;
        v.right_of_ego = v.adjacent && all_right;
        return v;
    endfunction

    function automatic logic [CW-1:0] to_coord(longint v);
        if (v > C_MAX)
            v = C_MAX;
        if (v < C_MIN)
            v = C_MIN;
        return v[CW-1:0];
    endfunction

    function automatic longint rand_between(longint lo, longint hi);
        longint unsigned r;
        r = {$urandom, $urandom};
        return lo + longint'(r % longint'(hi - lo + 1));
    endfunction

    // Directed rows; flags are {adjacent, left, right} where typed in.
    function automatic probe_row_t quad_row(logic [IDW-1:0] id, logic excl, logic known,
            logic [2:0] flags, longint x0, y0, x1, y1, x2, y2, x3, y3);
        probe_row_t row;
        row.box.id       = id;
        row.box.excluded = excl;
        row.box.x        = {to_coord(x3), to_coord(x2), to_coord(x1), to_coord(x0)};
        row.box.y        = {to_coord(y3), to_coord(y2), to_coord(y1), to_coord(y0)};
        row.known        = known;
        row.verdict      = {id, flags};
        return row;
    endfunction

    function automatic probe_row_t rect_row(logic [IDW-1:0] id, logic excl, logic known,
            logic [2:0] flags, longint xlo, xhi, ylo, yhi);
        return quad_row(id, excl, known, flags, xlo, ylo, xlo, yhi, xhi, yhi, xhi, ylo);
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(probe_row_t row);
        probe_rows = {probe_rows, row};
    endfunction

    task automatic compare_field(string field, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            errors++;
        end
    endtask

    // Result beat checker.
    always @(posedge aclk) begin
        side_verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result beat with id %0h arrived with nothing expected", m_result_id);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                compare_field("result_id", want.id, m_result_id);
                compare_field("adjacent", want.adjacent, m_adjacent);
                compare_field("left_of_ego", want.left_of_ego, m_left_of_ego);
                compare_field("right_of_ego", want.right_of_ego, m_right_of_ego);
            end
        end
    end

    // One obstacle beat, with a random gap in front of it.
    task automatic push_obstacle(obstacle_t b, side_verdict_t verdict);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < idle_pct);
        end
        s_valid       <= 1'b1;
        s_obstacle_id <= b.id;
        s_excluded    <= b.excluded;
        s_obs_v0_x    <= b.x[0];
        s_obs_v0_y    <= b.y[0];
        s_obs_v1_x    <= b.x[1];
        s_obs_v1_y    <= b.y[1];
        s_obs_v2_x    <= b.x[2];
        s_obs_v2_y    <= b.y[2];
        s_obs_v3_x    <= b.x[3];
        s_obs_v3_y    <= b.y[3];
        do @(posedge aclk); while (!s_ready);
        pending_verdicts = {pending_verdicts, verdict};
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge aclk);
    endtask

    // APB write; psel stays high across back-to-back writes.
    task automatic apb_write(bsc_reg_e idx, logic [CW-1:0] value);
        logic [APB_DATA_W-1:0] word;
        word          = $urandom;       // upper bits carry noise the block must drop
        word[CW-1:0]  = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    task automatic set_ego(input longint xs [4], input longint ys [4]);
        logic [CW-1:0] cx [4];
        logic [CW-1:0] cy [4];
        for (int i = 0; i < 4; i++) begin
            cx[i]    = to_coord(xs[i]);
            cy[i]    = to_coord(ys[i]);
            ego_x[i] = longint'($signed(cx[i]));
            ego_y[i] = longint'($signed(cy[i]));
        end
        apb_write(REG_EGO_V0_X, cx[0]);
        apb_write(REG_EGO_V0_Y, cy[0]);
        apb_write(REG_EGO_V1_X, cx[1]);
        apb_write(REG_EGO_V1_Y, cy[1]);
        apb_write(REG_EGO_V2_X, cx[2]);
        apb_write(REG_EGO_V2_Y, cy[2]);
        apb_write(REG_EGO_V3_X, cx[3]);
        apb_write(REG_EGO_V3_Y, cy[3]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stimulus.
    initial begin
        ego_shape_e plan [8] = '{SHAPE_ROTATED, SHAPE_RECT, SHAPE_WILD, SHAPE_ROTATED,
                                 SHAPE_EXTREME, SHAPE_DEGENERATE, SHAPE_RECT, SHAPE_ROTATED};
        longint     xs [4];
        longint     ys [4];
        longint     bx_lo, bx_hi, by_lo, by_hi, span, bx, by, w, h, xv, yv;
        longint     cx [4];
        longint     cy [4];
        int         roll;
        int         start;
        obstacle_t  b;

        // With the reset ego every cross product is zero, so nothing is adjacent.
        add_row(rect_row(16'h0000, 1'b0, 1'b1, NO_SIDE, 0, 0, 0, 0));
        add_row(rect_row(16'hFFFF, 1'b1, 1'b1, NO_SIDE, C_MAX, C_MAX, C_MAX, C_MAX));
        add_row(rect_row(16'h5A5A, 1'b0, 1'b1, NO_SIDE, C_MIN, C_MAX, C_MIN, C_MAX));
        add_row(rect_row(16'hA5A5, 1'b0, 1'b1, NO_SIDE, C_MIN, C_MIN, C_MIN, C_MIN));
        // Ego box spans x 0..10 and y 0..4; the band is between y = 0 and y = 4.
        add_row(rect_row(16'h0101, 1'b0, 1'b0, NO_SIDE, 2*U, 8*U, U, 3*U));
        add_row(rect_row(16'h0102, 1'b0, 1'b0, NO_SIDE, -6*U, -2*U, U, 3*U));
        add_row(rect_row(16'h0103, 1'b0, 1'b0, NO_SIDE, 12*U, 16*U, U, 3*U));
        add_row(rect_row(16'h0104, 1'b0, 1'b0, NO_SIDE, 2*U, 8*U, 6*U, 8*U));
        add_row(rect_row(16'h0105, 1'b0, 1'b0, NO_SIDE, 2*U, 8*U, -4*U, -U));
        add_row(rect_row(16'h0106, 1'b0, 1'b0, NO_SIDE, -6*U, 16*U, -2*U, 6*U));
        add_row(rect_row(16'h0107, 1'b0, 1'b0, NO_SIDE, 2*U, 8*U, 0, 0));
        add_row(rect_row(16'h0108, 1'b0, 1'b0, NO_SIDE, 2*U, 8*U, -3*U, 0));
        add_row(rect_row(16'h0109, 1'b0, 1'b0, NO_SIDE, 2*U, 8*U, 4*U, 7*U));
        add_row(rect_row(16'h010A, 1'b0, 1'b0, NO_SIDE, -4*U, 0, U, 3*U));
        add_row(rect_row(16'h010B, 1'b0, 1'b0, NO_SIDE, 10*U, 14*U, U, 3*U));
        // Excluded boxes report nothing, wherever they lie.
        add_row(rect_row(16'h010C, 1'b1, 1'b1, NO_SIDE, 2*U, 8*U, U, 3*U));
        add_row(rect_row(16'h010D, 1'b1, 1'b1, NO_SIDE, -6*U, -2*U, U, 3*U));
        add_row(rect_row(16'h0000, 1'b0, 1'b0, NO_SIDE, C_MIN, C_MAX, C_MIN, C_MAX));
        add_row(rect_row(16'hFFFF, 1'b0, 1'b1, NO_SIDE, C_MAX, C_MAX, C_MAX, C_MAX));
        add_row(rect_row(16'h8000, 1'b0, 1'b1, NO_SIDE, C_MIN, C_MIN, C_MIN, C_MIN));
        add_row(quad_row(16'h7FFF, 1'b0, 1'b0, NO_SIDE,
                         C_MIN, C_MIN, C_MAX, C_MAX, 5*U, 2*U, C_MIN, C_MAX));
        add_row(quad_row(16'h1234, 1'b0, 1'b0, NO_SIDE,
                         12*U, U, 16*U, U, 16*U, 3*U, 12*U, 3*U));
        add_row(quad_row(16'h4321, 1'b0, 1'b0, NO_SIDE,
                         -U, 2*U, -U, 2*U, -U, 2*U, -U, 2*U));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table.
        foreach (probe_rows[k]) begin
            if (k == RESET_ROWS) begin
                settle();
                xs = '{0, 0, 10*U, 10*U};
                ys = '{0, 4*U, 4*U, 0};
                set_ego(xs, ys);
            end
            push_obstacle(probe_rows[k].box,
                          probe_rows[k].known ? probe_rows[k].verdict
                                              : classify_box(probe_rows[k].box));
        end

        // Random phases, each with its own ego box.
        for (int p = 0; p < 8; p++) begin
            settle();
            case (plan[p])
                SHAPE_RECT: begin
                    bx = rand_between(C_MIN / 2, C_MAX / 2);
                    by = rand_between(C_MIN / 2, C_MAX / 2);
                    w  = rand_between(-65536, 65536);
                    h  = rand_between(-65536, 65536);
                    xs = '{bx, bx, bx + w, bx + w};
                    ys = '{by, by + h, by + h, by};
                end
                SHAPE_ROTATED: begin
                    bx = rand_between(-(1 << 21), 1 << 21);
                    by = rand_between(-(1 << 21), 1 << 21);
                    xv = rand_between(-64, 64);
                    yv = rand_between(-64, 64);
                    w  = rand_between(1, 256);
                    h  = rand_between(-256, 256);
                    xs[1] = bx;
                    ys[1] = by;
                    xs[2] = bx + w * xv;
                    ys[2] = by + w * yv;
                    xs[0] = bx - h * yv;
                    ys[0] = by + h * xv;
                    xs[3] = xs[0] + w * xv;
                    ys[3] = ys[0] + w * yv;
                end
                SHAPE_WILD: begin
                    for (int i = 0; i < 4; i++) begin
                        xs[i] = rand_between(C_MIN, C_MAX);
                        ys[i] = rand_between(C_MIN, C_MAX);
                    end
                end
                SHAPE_EXTREME: begin
                    xs = '{C_MIN, C_MIN, C_MAX, C_MAX};
                    ys = '{C_MIN, C_MAX, C_MAX, C_MIN};
                end
                default: begin
                    // Coincident corners; sometimes only the lateral edges collapse.
                    bx = rand_between(C_MIN, C_MAX);
                    by = rand_between(C_MIN, C_MAX);
                    xs = '{bx, bx, bx, bx};
                    ys = '{by, by, by, by};
                    if ($urandom_range(0, 1) == 1) begin
                        xs[0] = bx / 2;
                        xs[3] = bx / 2;
                        ys[0] = by / 2;
                        ys[3] = by / 2;
                    end
                end
            endcase
            set_ego(xs, ys);
            idle_pct = (p == 3) ? 0 : 26;

            // Bounding box of the ego, for dropping obstacles around it.
            bx_lo = ego_x[0];
            bx_hi = ego_x[0];
            by_lo = ego_y[0];
            by_hi = ego_y[0];
            for (int i = 1; i < 4; i++) begin
                if (ego_x[i] < bx_lo) bx_lo = ego_x[i];
                if (ego_x[i] > bx_hi) bx_hi = ego_x[i];
                if (ego_y[i] < by_lo) by_lo = ego_y[i];
                if (ego_y[i] > by_hi) by_hi = ego_y[i];
            end
            span = (bx_hi - bx_lo > by_hi - by_lo) ? bx_hi - bx_lo : by_hi - by_lo;
            if (span < U)
                span = U;

            repeat (PHASE_ITEMS) begin
                roll       = $urandom_range(0, 99);
                b.id       = IDW'($urandom);
                b.excluded = (roll < 10);
                if (roll < 30) begin
                    // Noise: corners anywhere in the coordinate range.
                    for (int i = 0; i < 4; i++) begin
                        b.x[i] = CW'($urandom);
                        b.y[i] = CW'($urandom);
                    end
                end else begin
                    // A box near the ego, some coordinates snapped onto ego corners
                    // so that corners land exactly on edge lines.
                    bx    = rand_between(bx_lo - span, bx_hi + span);
                    by    = rand_between(by_lo - span, by_hi + span);
                    w     = rand_between(0, span / 2);
                    h     = rand_between(0, span / 2);
                    cx    = '{bx, bx, bx + w, bx + w};
                    cy    = '{by, by + h, by + h, by};
                    start = $urandom_range(0, 3);
                    for (int i = 0; i < 4; i++) begin
                        xv = cx[(i + start) % 4];
                        yv = cy[(i + start) % 4];
                        if ($urandom_range(0, 3) == 0)
                            xv = ego_x[$urandom_range(0, 3)];
                        if ($urandom_range(0, 3) == 0)
                            yv = ego_y[$urandom_range(0, 3)];
                        b.x[i] = to_coord(xv);
                        b.y[i] = to_coord(yv);
                    end
                end
                push_obstacle(b, classify_box(b));
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("box_side_classifier_unit_test: done, clean");
        end else begin
            $display("box_side_classifier_unit_test: done, errors");
        end
        $finish;
    end

endmodule
